// File: hdl/lrprc_pkg.sv
// ----------------------------------------------------------------------------
// lrprc_pkg
// Shared types and constants for the lock relay pulse/retry controller.
// ----------------------------------------------------------------------------
package lrprc_pkg;

  // controller phases as seen on the result word
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PULSE  = 3'd1,
    PH_SETTLE = 3'd2,
    PH_RETRY  = 3'd3,
    PH_HOLD   = 3'd4
  } phase_t;

  // configuration register indexes
  localparam logic [2:0] REG_PULSE_TIME    = 3'd0;
  localparam logic [2:0] REG_SETTLE_TIME   = 3'd1;
  localparam logic [2:0] REG_RETRY_DELAY   = 3'd2;
  localparam logic [2:0] REG_HOLD_OFF_TIME = 3'd3;
  localparam logic [2:0] REG_MAX_RETRIES   = 3'd4;

  // widths
  localparam int TIME_W  = 16;
  localparam int RETRY_W = 4;
  localparam int CHECK_W = 5;

  // register reset values
  localparam logic [TIME_W-1:0]  PULSE_TIME_RST    = 16'd500;
  localparam logic [TIME_W-1:0]  SETTLE_TIME_RST   = 16'd100;
  localparam logic [TIME_W-1:0]  RETRY_DELAY_RST   = 16'd1000;
  localparam logic [TIME_W-1:0]  HOLD_OFF_TIME_RST = 16'd2000;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST   = 4'd3;

  localparam logic [TIME_W-1:0] TICKS_MAX = 16'hFFFF;

endpackage

// File: hdl/lock_relay_pulse_retry_controller_unit.sv
// ----------------------------------------------------------------------------
// lock_relay_pulse_retry_controller_unit
// Tick-driven relay pulse, settle check and retry sequencer for a door lock.
// ----------------------------------------------------------------------------
// Usage:
//   Each word on the s_ group is one millisecond tick carrying the open
//   request pulse and the lock sensor level. For every accepted tick the
//   block returns exactly one result word on the m_ group: relay drive,
//   failure flag and current phase, all taken after that tick's update.
//   The user loads timing registers through cfg_we/cfg_index/cfg_data while the block is
//   idle; the block does not enforce this. Indexes above the register list are ignored.
// Result timing and throughput:
//   The result of a tick is registered and shows on m_tdata in the cycle after it is accepted.
//   One tick is accepted per clock while the result is not stalled; the sequencer state and the result
//   register update in the same edge, so back-to-back ticks run at full rate.
// Reset:
//   rst clears the phase to idle, the tick counter, retry count, request
//   latch, failure flag and relay, loads the register defaults and empties
//   the result register.
// Stall:
//   While a result waits and m_tready is low, s_tready drops; a tick is taken
//   in the same cycle the waiting result is taken.
// ----------------------------------------------------------------------------
module lock_relay_pulse_retry_controller_unit (
  input  logic        clk,
  input  logic        rst,
  // tick input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] open_request, [1] lock_sensed_open, [7:2] zero
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] relay_drive, [1] open_failed, [4:2] phase, [7:5] zero
  // configuration write
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int TW = lrprc_pkg::TIME_W;
  localparam int RW = lrprc_pkg::RETRY_W;
  localparam int CW = lrprc_pkg::CHECK_W;

  // configuration registers
  logic [TW-1:0] pulse_time;
  logic [TW-1:0] settle_time;
  logic [TW-1:0] retry_delay;
  logic [TW-1:0] hold_off_time;
  logic [RW-1:0] max_retries;

  // sequencer state
  lrprc_pkg::phase_t phase, phase_next;
  logic [TW-1:0] elapsed, elapsed_next;
  logic [CW-1:0] failed_checks, failed_checks_next;
  logic          request_pending, request_pending_next;
  logic          failure_flag, failure_flag_next;
  logic          relay, relay_next;

  logic open_request;
  logic lock_sensed_open;
  logic accept;

  logic [TW-1:0] limit;
  logic          timed_out;
  logic [TW-1:0] elapsed_inc;
  logic          more_retries;

  assign open_request     = s_tdata[0];
  assign lock_sensed_open = s_tdata[1];
  assign s_tready         = !m_tvalid || m_tready;
  assign accept           = s_tvalid && s_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_time    <= lrprc_pkg::PULSE_TIME_RST;
      settle_time   <= lrprc_pkg::SETTLE_TIME_RST;
      retry_delay   <= lrprc_pkg::RETRY_DELAY_RST;
      hold_off_time <= lrprc_pkg::HOLD_OFF_TIME_RST;
      max_retries   <= lrprc_pkg::MAX_RETRIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lrprc_pkg::REG_PULSE_TIME:    pulse_time    <= cfg_data;
        lrprc_pkg::REG_SETTLE_TIME:   settle_time   <= cfg_data;
        lrprc_pkg::REG_RETRY_DELAY:   retry_delay   <= cfg_data;
        lrprc_pkg::REG_HOLD_OFF_TIME: hold_off_time <= cfg_data;
        lrprc_pkg::REG_MAX_RETRIES:   max_retries   <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // time limit of the current phase; idle counts toward saturation
  always_comb begin
    case (phase)
      lrprc_pkg::PH_PULSE:  limit = pulse_time;
      lrprc_pkg::PH_SETTLE: limit = settle_time;
      lrprc_pkg::PH_RETRY:  limit = retry_delay;
      lrprc_pkg::PH_HOLD:   limit = hold_off_time;
      default:              limit = lrprc_pkg::TICKS_MAX;
    endcase
  end

  assign timed_out    = elapsed >= limit;
  assign elapsed_inc  = (elapsed == lrprc_pkg::TICKS_MAX) ? elapsed : elapsed + TW'(1);
  assign more_retries = failed_checks < {1'b0, max_retries};

  // next state for one tick
  always_comb begin
    phase_next           = phase;
    elapsed_next         = timed_out ? elapsed : elapsed_inc;
    failed_checks_next   = failed_checks;
    request_pending_next = request_pending || open_request;
    failure_flag_next    = failure_flag;
    relay_next           = relay;
    case (phase)
      lrprc_pkg::PH_PULSE: begin
        if (timed_out) begin
          relay_next   = 1'b0;
          phase_next   = lrprc_pkg::PH_SETTLE;
          elapsed_next = '0;
        end
      end
      lrprc_pkg::PH_SETTLE: begin
        if (timed_out) begin
          elapsed_next = '0;
          if (lock_sensed_open) begin
            phase_next = lrprc_pkg::PH_HOLD;
          end else begin
            failed_checks_next = failed_checks + CW'(1);
            if (more_retries) begin
              phase_next = lrprc_pkg::PH_RETRY;
            end else begin
              failure_flag_next = 1'b1;
              phase_next        = lrprc_pkg::PH_HOLD;
            end
          end
        end
      end
      lrprc_pkg::PH_RETRY: begin
        if (timed_out) begin
          phase_next   = lrprc_pkg::PH_IDLE;
          elapsed_next = '0;
        end
      end
      lrprc_pkg::PH_HOLD: begin
        if (timed_out) begin
          failed_checks_next   = '0;
          request_pending_next = 1'b0;
          failure_flag_next    = 1'b0;
          phase_next           = lrprc_pkg::PH_IDLE;
          elapsed_next         = '0;
        end
      end
      default: begin
        phase_next = lrprc_pkg::PH_IDLE;
        if (request_pending_next) begin
          relay_next   = 1'b1;
          phase_next   = lrprc_pkg::PH_PULSE;
          elapsed_next = '0;
        end
      end
    endcase
  end

  // state update on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lrprc_pkg::PH_IDLE;
      elapsed         <= '0;
      failed_checks   <= '0;
      request_pending <= 1'b0;
      failure_flag    <= 1'b0;
      relay           <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      elapsed         <= elapsed_next;
      failed_checks   <= failed_checks_next;
      request_pending <= request_pending_next;
      failure_flag    <= failure_flag_next;
      relay           <= relay_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, phase_next, failure_flag_next, relay_next};
    end
  end

endmodule

// File: hdl/lrprc_checker.sv
// ----------------------------------------------------------------------------
// lrprc_checker
// Port-level checks for the lock relay pulse/retry controller.
// ----------------------------------------------------------------------------
module lrprc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // relay is energized exactly while pulsing
  a_relay_pulse: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[4:2] == lrprc_pkg::PH_PULSE)))
    else $error("relay drive does not match pulse phase");

  // failure flag only shows during hold-off
  a_fail_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> (m_tdata[4:2] == lrprc_pkg::PH_HOLD))
    else $error("failure flag outside hold-off");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // input only stalls behind a waiting result word
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled with no waiting result");

endmodule

bind lock_relay_pulse_retry_controller_unit lrprc_checker u_lrprc_checker (.*);
